// File: hdl/assert_macros.svh
// Assertion macros used by the framer checker RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Property must hold at every rising clock edge outside reset.
`define NSFC_ASSERT(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Expression must never be true at a rising clock edge outside reset.
`define NSFC_NEVER(lbl, clk, rstn, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) else $error(msg);
`else
`define NSFC_ASSERT(lbl, clk, rstn, prop, msg)
`define NSFC_NEVER(lbl, clk, rstn, expr, msg)
`endif

`endif

// File: hdl/nsfc_pkg.sv
// Types and constants of the NMEA sentence framer checker.
package nsfc_pkg;

	// Framing phase of the receiver.
	typedef enum logic [2:0] {
		PH_IDLE,
		PH_BODY,
		PH_HEX1,
		PH_HEX2,
		PH_CR,
		PH_LF
	} phase_t;

	// How a sentence ended.
	typedef enum logic [2:0] {
		OUT_GOOD,
		OUT_MISMATCH,
		OUT_BAD_TAIL,
		OUT_CUT,
		OUT_TOO_LONG
	} outcome_t;

	// Sentence type codes.
	localparam logic [2:0] TYPE_UNKNOWN = 3'd0;

	// Framing characters.
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_LF     = 8'h0A;

	localparam int NUM_HDR = 5;
	localparam int HDR_LEN = 5;

	// Candidate headers: GPGGA, GPGSA, GPGSV, GPRMC, GPVTG.
	localparam logic [7:0] HEADERS [NUM_HDR][HDR_LEN] = '{
		'{"G", "P", "G", "G", "A"},
		'{"G", "P", "G", "S", "A"},
		'{"G", "P", "G", "S", "V"},
		'{"G", "P", "R", "M", "C"},
		'{"G", "P", "V", "T", "G"}
	};

	// One result item; the first field sits in the highest bits when packed.
	typedef struct packed {
		logic [7:0] sentence_length;
		logic [7:0] computed_checksum;
		logic [7:0] received_checksum;
		outcome_t   outcome;
		logic [2:0] sentence_type;
	} result_t;

endpackage

// File: hdl/nsfc_in_reg.sv
// Input register stage that holds one received byte until the core takes it.
module nsfc_in_reg import nsfc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] rx_byte
	input  logic       advance,
	output logic       valid_s1,
	output logic [7:0] byte_s1
);

	logic accept;

	// The stage takes a new byte when empty or when its byte moves on.
	assign s_tready = !valid_s1 || advance;
	assign accept   = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept || (valid_s1 && !advance);
		end
	end

	// Payload needs no reset.
	always_ff @(posedge clk) begin
		if (accept) begin
			byte_s1 <= s_tdata;
		end
	end

endmodule

// File: hdl/nsfc_core.sv
// Framing state, checksum and header matching for one byte per cycle while bytes are taken.
module nsfc_core import nsfc_pkg::*; #(
	parameter int unsigned MAX_SENTENCE = 128
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       take,
	input  logic [7:0] rx_byte,
	output logic       res_valid,
	output result_t    res
);

	localparam logic [7:0] MAX_LEN = 8'(MAX_SENTENCE);

	phase_t             phase_q, phase_n;
	logic [7:0]         xor_q, xor_n;
	logic [7:0]         given_q, given_n;
	logic [NUM_HDR-1:0] match_q, match_n;
	logic [7:0]         count_q, count_n;
	logic               bad_q, bad_n;

	logic [2:0]         type_code;
	logic [2:0]         pos;
	logic [4:0]         nib;
	logic               tail_bad;

	// Hex digit to nibble, with a valid flag in the top bit.
	function automatic logic [4:0] hex_nibble(input logic [7:0] c);
		logic [4:0] r;
		r = 5'd0;
		if (c >= "0" && c <= "9") begin
			r = {1'b1, 4'(c - "0")};
		end else if (c >= "A" && c <= "F") begin
			r = {1'b1, 4'(c - "A" + 8'd10)};
		end else if (c >= "a" && c <= "f") begin
			r = {1'b1, 4'(c - "a" + 8'd10)};
		end
		return r;
	endfunction

	// Type from the first header still matching; none while the header is short.
	always_comb begin
		type_code = TYPE_UNKNOWN;
		if (!(phase_q == PH_BODY && count_q < 8'd6)) begin
			for (int i = NUM_HDR - 1; i >= 0; i--) begin
				if (match_q[i]) begin
					type_code = 3'(i + 1);
				end
			end
		end
	end

	assign pos = 3'(count_q - 8'd1);
	assign nib = hex_nibble(rx_byte);

	// Next state and result.
	always_comb begin
		phase_n   = phase_q;
		xor_n     = xor_q;
		given_n   = given_q;
		match_n   = match_q;
		count_n   = count_q;
		bad_n     = bad_q;
		tail_bad  = bad_q;
		res_valid = 1'b0;
		res.sentence_type     = type_code;
		res.outcome           = OUT_GOOD;
		res.received_checksum = given_q;
		res.computed_checksum = xor_q;
		res.sentence_length   = count_q;

		case (phase_q)
			PH_BODY, PH_HEX1, PH_HEX2, PH_CR, PH_LF: begin
				if (rx_byte == CH_DOLLAR) begin
					// A new sentence cuts the current one short.
					res_valid   = 1'b1;
					res.outcome = OUT_CUT;
					phase_n     = PH_BODY;
					xor_n       = 8'd0;
					given_n     = 8'd0;
					match_n     = '1;
					count_n     = 8'd1;
					bad_n       = 1'b0;
				end else if (count_q >= MAX_LEN) begin
					res_valid           = 1'b1;
					res.outcome         = OUT_TOO_LONG;
					res.sentence_length = MAX_LEN;
					phase_n             = PH_IDLE;
				end else begin
					count_n = count_q + 8'd1;
					case (phase_q)
						PH_BODY: begin
							if (rx_byte == CH_STAR) begin
								if (count_q < 8'd6) begin
									match_n = '0;
								end
								phase_n = PH_HEX1;
							end else begin
								xor_n = xor_q ^ rx_byte;
								if (count_q >= 8'd1 && count_q <= 8'(HDR_LEN)) begin
									for (int i = 0; i < NUM_HDR; i++) begin
										if (HEADERS[i][pos] != rx_byte) begin
											match_n[i] = 1'b0;
										end
									end
								end
							end
						end
						PH_HEX1: begin
							given_n = {nib[3:0], 4'd0};
							if (!nib[4]) begin
								bad_n = 1'b1;
							end
							phase_n = PH_HEX2;
						end
						PH_HEX2: begin
							given_n = {given_q[7:4], nib[3:0]};
							if (!nib[4]) begin
								bad_n = 1'b1;
							end
							phase_n = PH_CR;
						end
						PH_CR: begin
							if (rx_byte != CH_CR) begin
								bad_n = 1'b1;
							end
							phase_n = PH_LF;
						end
						default: begin
							// Last tail byte closes the sentence.
							tail_bad = bad_q || (rx_byte != CH_LF);
							res_valid           = 1'b1;
							res.sentence_length = count_n;
							if (tail_bad) begin
								res.outcome = OUT_BAD_TAIL;
							end else if (given_q != xor_q) begin
								res.outcome = OUT_MISMATCH;
							end else begin
								res.outcome = OUT_GOOD;
							end
							bad_n   = tail_bad;
							phase_n = PH_IDLE;
						end
					endcase
				end
			end
			default: begin
				// Outside a sentence only a dollar sign matters.
				if (rx_byte == CH_DOLLAR) begin
					phase_n = PH_BODY;
					xor_n   = 8'd0;
					given_n = 8'd0;
					match_n = '1;
					count_n = 8'd1;
					bad_n   = 1'b0;
				end else begin
					phase_n = PH_IDLE;
				end
			end
		endcase
	end

	// State registers advance only when a byte is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			xor_q   <= 8'd0;
			given_q <= 8'd0;
			match_q <= '1;
			count_q <= 8'd0;
			bad_q   <= 1'b0;
		end else if (take) begin
			phase_q <= phase_n;
			xor_q   <= xor_n;
			given_q <= given_n;
			match_q <= match_n;
			count_q <= count_n;
			bad_q   <= bad_n;
		end
	end

endmodule

// File: hdl/nsfc_out_reg.sv
// Output register that holds a finished result until it is transferred.
module nsfc_out_reg import nsfc_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    advance,
	input  logic    res_valid,
	input  result_t res,
	output logic    can_load,
	output logic    m_tvalid,
	input  logic    m_tready,
	output result_t res_q
);

	// The register may load when empty or when its result leaves now.
	assign can_load = !m_tvalid || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (can_load) begin
			m_tvalid <= advance && res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (can_load && advance && res_valid) begin
			res_q <= res;
		end
	end

endmodule

// File: hdl/nmea_sentence_framer_checker_top.sv
// A sentence's last byte passes the input register; its result loads the output register.
// One byte per cycle, set by the framing state update, while the output is not stalled.
// The input register takes a byte while a finished result waits in the output register.
// Reset (arst_n low, asynchronous) empties both registers and returns the framer to idle.
// After reset the block accepts bytes at once; no clearing pass is needed.
module nmea_sentence_framer_checker_top import nsfc_pkg::*; #(
	parameter int unsigned MAX_SENTENCE = 128
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] rx_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata    // [2:0] sentence_type, [5:3] outcome,
	                               // [13:6] received_checksum,
	                               // [21:14] computed_checksum,
	                               // [29:22] sentence_length, [31:30] zero
);

`include "assert_macros.svh"

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       can_load;
	logic       advance;
	logic       res_valid;
	result_t    res;
	result_t    res_q;

	// A held byte moves on whenever the output register can take its result.
	assign advance = valid_s1 && can_load;

	nsfc_in_reg u_in_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.byte_s1  (byte_s1)
	);

	nsfc_core #(
		.MAX_SENTENCE (MAX_SENTENCE)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (advance),
		.rx_byte   (byte_s1),
		.res_valid (res_valid),
		.res       (res)
	);

	nsfc_out_reg u_out_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (advance),
		.res_valid (res_valid),
		.res       (res),
		.can_load  (can_load),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.res_q     (res_q)
	);

	assign m_tdata = {2'b00, res_q};

	// A reported length never exceeds the sentence limit.
	`NSFC_NEVER(a_len_limit, clk, arst_n, m_tvalid && (res_q.sentence_length > 8'(MAX_SENTENCE)), "sentence length above limit")
	// A good sentence carries matching checksums.
	`NSFC_ASSERT(a_good_sum, clk, arst_n, (m_tvalid && res_q.outcome == OUT_GOOD) |-> (res_q.received_checksum == res_q.computed_checksum), "good outcome with checksum mismatch")
	// A known type needs a full header, so the sentence has at least six bytes.
	`NSFC_ASSERT(a_type_len, clk, arst_n, (m_tvalid && res_q.sentence_type != TYPE_UNKNOWN) |-> (res_q.sentence_length >= 8'd6), "known type on a short sentence")
	// A complete tail means at least dollar, star, two digits, CR and LF.
	`NSFC_ASSERT(a_tail_len, clk, arst_n, (m_tvalid && (res_q.outcome == OUT_GOOD || res_q.outcome == OUT_MISMATCH || res_q.outcome == OUT_BAD_TAIL)) |-> (res_q.sentence_length >= 8'd6), "tail outcome on too few bytes")

endmodule

// File: dv/tb.sv
// Self-checking testbench for the NMEA sentence framer checker, byte stream in, verdicts out.
`timescale 1ns / 1ps

module tb;
	import nsfc_pkg::*;

	localparam int MAX_LEN = 128;
	localparam int IDLE_PCT = 21;
	localparam int HOLD_CYCLES = 400;
	localparam int DRAIN_CYCLES = 8;
	localparam int RANDOM_BYTES = 600;

	// Sentence type codes beyond the unknown one.
	localparam logic [2:0] TYPE_GGA = 3'd1;

	typedef struct {
		logic [7:0] ch;
		bit         typed;
		result_t    res;
	} stim_row_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;   // [7:0] rx_byte
	logic        m_tvalid;
	logic        m_tready;
	logic [31:0] m_tdata;   // [2:0] sentence_type, [5:3] outcome, [13:6] received_checksum,
	                        // [21:14] computed_checksum, [29:22] sentence_length

	// Shared control between the sender and the receiver.
	bit calm;
	bit hold_off_req;
	int mismatch_count;

	// Predictor state of the framer.
	phase_t     frame_phase;
	logic [7:0] xor_acc;
	logic [7:0] hex_value;
	logic [4:0] hdr_alive;
	logic [7:0] frame_len;
	logic       tail_err;

	result_t   verdict_q[$];
	stim_row_t directed_q[$];

	nmea_sentence_framer_checker_top #(
		.MAX_SENTENCE(MAX_LEN)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Hard stop in case the block hangs.
	initial begin
		#1_000_000;
		$display("nmea_sentence_framer_checker_top test failed");
		$finish;
	end

	function automatic result_t make_verdict(input logic [2:0] kind, input outcome_t how,
		input logic [7:0] given, input logic [7:0] sum, input logic [7:0] len);
		result_t r;
		r.sentence_type = kind;
		r.outcome = how;
		r.received_checksum = given;
		r.computed_checksum = sum;
		r.sentence_length = len;
		return r;
	endfunction

	// A '$' opens a fresh sentence with the dollar itself counted.
	function automatic void start_frame();
		frame_phase = PH_BODY;
		xor_acc = '0;
		hex_value = '0;
		hdr_alive = '1;
		frame_len = 8'd1;
		tail_err = 1'b0;
	endfunction

	// The first header still alive wins; too few body bytes means unknown.
	function automatic logic [2:0] frame_type();
		if (frame_phase == PH_BODY && frame_len < 8'd6)
			return TYPE_UNKNOWN;
		for (int i = 0; i < NUM_HDR; i++)
			if (hdr_alive[i])
				return 3'(i + 1);
		return TYPE_UNKNOWN;
	endfunction

	function automatic result_t close_frame(input outcome_t how, input logic [7:0] len);
		return make_verdict(frame_type(), how, hex_value, xor_acc, len);
	endfunction

	// Value of one hex digit in either case; anything else reads as zero.
	function automatic logic [3:0] nibble_of(input logic [7:0] c, output bit ok);
		ok = 1'b1;
		if (c >= "0" && c <= "9")
			return 4'(c - "0");
		if (c >= "A" && c <= "F")
			return 4'(c - "A" + 8'd10);
		if (c >= "a" && c <= "f")
			return 4'(c - "a" + 8'd10);
		ok = 1'b0;
		return 4'h0;
	endfunction

	// Advance the predicted framer by one byte; returns 1 when a verdict comes out.
	function automatic bit frame_byte(input logic [7:0] c, output result_t res);
		int pos;
		bit ok;
		res = '0;
		if (frame_phase == PH_IDLE) begin
			if (c == CH_DOLLAR)
				start_frame();
			return 1'b0;
		end
		if (c == CH_DOLLAR) begin
			res = close_frame(OUT_CUT, frame_len);
			start_frame();
			return 1'b1;
		end
		if (frame_len >= 8'(MAX_LEN)) begin
			res = close_frame(OUT_TOO_LONG, 8'(MAX_LEN));
			frame_phase = PH_IDLE;
			return 1'b1;
		end
		frame_len++;
		case (frame_phase)
			PH_BODY: begin
				if (c == CH_STAR) begin
					if (frame_len < 8'd7)
						hdr_alive = '0;
					frame_phase = PH_HEX1;
				end else begin
					xor_acc ^= c;
					pos = int'(frame_len) - 2;
					if (pos < HDR_LEN)
						for (int i = 0; i < NUM_HDR; i++)
							if (HEADERS[i][pos] != c)
								hdr_alive[i] = 1'b0;
				end
			end
			PH_HEX1: begin
				hex_value = {nibble_of(c, ok), 4'h0};
				if (!ok)
					tail_err = 1'b1;
				frame_phase = PH_HEX2;
			end
			PH_HEX2: begin
				hex_value[3:0] = nibble_of(c, ok);
				if (!ok)
					tail_err = 1'b1;
				frame_phase = PH_CR;
			end
			PH_CR: begin
				if (c != CH_CR)
					tail_err = 1'b1;
				frame_phase = PH_LF;
			end
			default: begin
				if (c != CH_LF)
					tail_err = 1'b1;
				if (tail_err)
					res = close_frame(OUT_BAD_TAIL, frame_len);
				else if (hex_value != xor_acc)
					res = close_frame(OUT_MISMATCH, frame_len);
				else
					res = close_frame(OUT_GOOD, frame_len);
				frame_phase = PH_IDLE;
				return 1'b1;
			end
		endcase
		return 1'b0;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("[%0t] MISMATCH %s", $realtime, msg);
		mismatch_count++;
	endtask

	task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s: got %0h, expected %0h", name, got, want));
	endtask

	// Offer one byte, wait for its transfer, and record what it should produce.
	task automatic send_byte(input logic [7:0] c, input bit typed, input result_t typed_res);
		result_t predicted;
		bit produces;
		while (!calm && $urandom_range(99) < IDLE_PCT) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= c;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		produces = frame_byte(c, predicted);
		if (typed)
			verdict_q.push_back(typed_res);
		else if (produces)
			verdict_q.push_back(predicted);
		@(negedge clk);
	endtask

	task automatic add_row(input logic [7:0] c, input bit typed, input result_t res);
		stim_row_t row;
		row.ch = c;
		row.typed = typed;
		row.res = res;
		directed_q.push_back(row);
	endtask

	task automatic add_text(input string s);
		for (int i = 0; i < s.len(); i++)
			add_row(s[i], 1'b0, '0);
	endtask

	// Body characters: mostly printable, sometimes any byte, never a dollar or a star.
	function automatic logic [7:0] body_char();
		logic [7:0] c;
		do begin
			if ($urandom_range(9) == 0)
				c = 8'($urandom_range(255));
			else
				c = 8'($urandom_range(8'h7E, 8'h20));
		end while (c == CH_DOLLAR || c == CH_STAR);
		return c;
	endfunction

	function automatic logic [7:0] hex_char(input logic [3:0] v);
		if (v < 4'd10)
			return "0" + 8'(v);
		return (($urandom_range(1) == 1) ? "a" : "A") + 8'(v) - 8'd10;
	endfunction

	// Build one sentence, damage it now and then, and send it.
	task automatic send_random_sentence(input bit long_body, output int sent);
		logic [7:0] frame[$];
		logic [7:0] sum;
		logic [7:0] given;
		int hdr;
		int extra;
		int cut_at;
		sum = '0;
		frame.push_back(CH_DOLLAR);
		hdr = $urandom_range(6);
		if (hdr < NUM_HDR)
			for (int k = 0; k < HDR_LEN; k++)
				frame.push_back(HEADERS[hdr][k]);
		// A long body always runs past the length limit.
		extra = long_body ? $urandom_range(135, 124) : $urandom_range(12);
		for (int k = 0; k < extra; k++)
			frame.push_back(body_char());
		for (int k = 1; k < frame.size(); k++)
			sum ^= frame[k];
		given = ($urandom_range(3) == 0) ? 8'($urandom_range(255)) : sum;
		frame.push_back(CH_STAR);
		frame.push_back(hex_char(given[7:4]));
		frame.push_back(hex_char(given[3:0]));
		frame.push_back(CH_CR);
		frame.push_back(CH_LF);
		// Replace one of the four tail bytes with anything at all.
		if ($urandom_range(9) == 0)
			frame[frame.size() - 1 - $urandom_range(3)] = 8'($urandom_range(255));
		// Leave some short sentences unfinished so the next dollar interrupts them.
		if (!long_body && $urandom_range(7) == 0) begin
			cut_at = $urandom_range(frame.size() - 1, 1);
			frame = frame[0:cut_at - 1];
		end
		foreach (frame[k])
			send_byte(frame[k], 1'b0, '0);
		sent = frame.size();
		// Line noise between sentences.
		if ($urandom_range(6) == 0)
			repeat ($urandom_range(4, 1))
				send_byte(8'($urandom_range(255)), 1'b0, '0);
	endtask

	// Receiver: random back-pressure, a quiet stretch, and one long hold-off.
	initial begin
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_off_req) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES)
					@(negedge clk);
				hold_off_req = 1'b0;
			end
			m_tready <= arst_n && (calm || $urandom_range(99) >= IDLE_PCT);
		end
	end

	// Compare each verdict transfer with the oldest prediction.
	always @(posedge clk) begin
		result_t got;
		result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = result_t'(m_tdata[29:0]);
			if (verdict_q.size() == 0) begin
				report_mismatch($sformatf("unexpected verdict %h", m_tdata));
			end else begin
				want = verdict_q.pop_front();
				check_field("sentence_type", 8'(got.sentence_type), 8'(want.sentence_type));
				check_field("outcome", 8'(got.outcome), 8'(want.outcome));
				check_field("received_checksum", got.received_checksum, want.received_checksum);
				check_field("computed_checksum", got.computed_checksum, want.computed_checksum);
				check_field("sentence_length", got.sentence_length, want.sentence_length);
				check_field("padding", 8'(m_tdata[31:30]), 8'd0);
			end
		end
	end

	// Reset, directed table, random sentences, then drain.
	initial begin
		int framed;
		int sent;
		int sentence_no;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		calm = 1'b0;
		hold_off_req = 1'b0;
		mismatch_count = 0;
		frame_phase = PH_IDLE;
		xor_acc = '0;
		hex_value = '0;
		hdr_alive = '1;
		frame_len = '0;
		tail_err = 1'b0;

		// Stray extremes, a good GGA sentence, an interrupted one, a bad tail,
		// and a mismatch written with mixed-case hex digits.
		add_row(8'h00, 1'b0, '0);
		add_row(8'hFF, 1'b0, '0);
		add_text("$GPGGA*56");
		add_row(CH_CR, 1'b0, '0);
		add_row(CH_LF, 1'b1, make_verdict(TYPE_GGA, OUT_GOOD, 8'h56, 8'h56, 8'd11));
		add_text("$*");
		add_row(CH_DOLLAR, 1'b1, make_verdict(TYPE_UNKNOWN, OUT_CUT, 8'h00, 8'h00, 8'd2));
		add_text("*g0x");
		add_row(CH_LF, 1'b1, make_verdict(TYPE_UNKNOWN, OUT_BAD_TAIL, 8'h00, 8'h00, 8'd6));
		add_text("$*fF");
		add_row(CH_CR, 1'b0, '0);
		add_row(CH_LF, 1'b1, make_verdict(TYPE_UNKNOWN, OUT_MISMATCH, 8'hFF, 8'h00, 8'd6));

		repeat (3)
			@(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (directed_q[i])
			send_byte(directed_q[i].ch, directed_q[i].typed, directed_q[i].res);

		// One long sentence first so the length limit is always reached.
		send_random_sentence(1'b1, sent);
		framed = sent;
		sentence_no = 0;
		while (framed < RANDOM_BYTES) begin
			calm = (sentence_no >= 5 && sentence_no < 12);
			if (sentence_no == 15)
				hold_off_req = 1'b1;
			send_random_sentence($urandom_range(24) == 0, sent);
			framed += sent;
			sentence_no++;
		end
		calm = 1'b0;
		s_tvalid <= 1'b0;

		while (verdict_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES)
			@(posedge clk);
		if (mismatch_count == 0)
			$display("nmea_sentence_framer_checker_top test passed");
		else
			$display("nmea_sentence_framer_checker_top test failed");
		$finish;
	end

endmodule
